// File: rtl/sacfd_pkg.sv
// sacfd_pkg: shared types and constants of the sum/add check frame deframer.
// No dependencies; used by the interfaces and every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package sacfd_pkg;

	localparam int BYTE_W    = 8;
	localparam int KIND_W    = 2;
	localparam int CFG_IDX_W = 2;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [KIND_W-1:0] KIND_GOOD    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_BAD     = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_HEADER_VALUE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_ADDRESS = 2'd1;

	localparam logic [BYTE_W-1:0] HEADER_RESET  = 8'hAA;
	localparam logic [BYTE_W-1:0] ADDRESS_RESET = 8'h00;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [BYTE_W-1:0] data_byte;
		logic [BYTE_W-1:0] frame_id;
		logic [BYTE_W-1:0] byte_index;
		logic [BYTE_W-1:0] frame_length;
	} result_t;

	typedef struct packed {
		logic [BYTE_W-1:0] header_value;
		logic [BYTE_W-1:0] accept_address;
	} cfg_regs_t;

endpackage

`default_nettype wire

// File: rtl/sacfd_ifs.sv
// sacfd_ifs: valid/ready channel interfaces of the deframer (byte in, result out,
// configuration write). Depends on sacfd_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

interface sacfd_byte_if;
	logic                          valid;
	logic                          ready;
	logic [sacfd_pkg::BYTE_W-1:0]  rx_byte;
	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sacfd_result_if;
	logic                          valid;
	logic                          ready;
	logic [sacfd_pkg::KIND_W-1:0]  kind;
	logic [sacfd_pkg::BYTE_W-1:0]  data_byte;
	logic [sacfd_pkg::BYTE_W-1:0]  frame_id;
	logic [sacfd_pkg::BYTE_W-1:0]  byte_index;
	logic [sacfd_pkg::BYTE_W-1:0]  frame_length;
	modport source (output valid, output kind, output data_byte, output frame_id,
		output byte_index, output frame_length, input ready);
	modport sink   (input valid, input kind, input data_byte, input frame_id,
		input byte_index, input frame_length, output ready);
endinterface

interface sacfd_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [sacfd_pkg::CFG_IDX_W-1:0] index;
	logic [sacfd_pkg::BYTE_W-1:0]    data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/sum_add_check_frame_deframer.sv
// Sum/add check frame deframer, top level.
// Byte in on rx (valid/ready, rx_byte); results out on res; register writes on cfg.
// Frames: header, address, id, length L, L payload bytes, sum check, add check.
// Non-header bytes are dropped while hunting. For a frame whose address matches
// accept_address, each payload byte comes out as kind payload with its index,
// and the add check byte gives one good or bad result. Other frames yield nothing.
// Throughput: one byte per cycle while rx.ready is high. The result (if any) of an
// accepted byte is written into the result buffer at the edge that accepts it.
// A two-entry result buffer sits before res: rx.ready drops only when both
// entries hold results the consumer has not taken, so a stalled receiver
// backs up rx after two results. Reset (arst_n low) clears the parser to
// hunting, empties the buffer, and loads header_value 0xAA, accept_address 0.
// cfg: index 0 header_value, 1 accept_address, other indexes ignored;
// cfg.ready is always high, writes are meant for idle time only.
`timescale 1ns / 1ps
`default_nettype none

module sum_add_check_frame_deframer (
	input  wire logic       clk,
	input  wire logic       arst_n,
	sacfd_byte_if.sink      rx,
	sacfd_result_if.source  res,
	sacfd_cfg_if.sink       cfg
);

	sacfd_pkg::cfg_regs_t regs_q;
	sacfd_pkg::result_t   core_res;
	sacfd_pkg::result_t   buf_res;
	logic                 core_valid;
	logic                 take;
	logic                 not_full;

	assign cfg.ready = 1'b1;
	assign rx.ready  = not_full;
	assign take      = rx.valid && not_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.header_value   <= sacfd_pkg::HEADER_RESET;
			regs_q.accept_address <= sacfd_pkg::ADDRESS_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				sacfd_pkg::REG_HEADER_VALUE:   regs_q.header_value   <= cfg.data;
				sacfd_pkg::REG_ACCEPT_ADDRESS: regs_q.accept_address <= cfg.data;
				default:                       regs_q                <= regs_q;
			endcase
		end
	end

	sacfd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.rx_byte   (rx.rx_byte),
		.regs      (regs_q),
		.res_valid (core_valid),
		.res       (core_res)
	);

	sacfd_outbuf u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (take && core_valid),
		.wr_data  (core_res),
		.not_full (not_full),
		.rd_valid (res.valid),
		.rd_ready (res.ready),
		.rd_data  (buf_res)
	);

	assign res.kind         = buf_res.kind;
	assign res.data_byte    = buf_res.data_byte;
	assign res.frame_id     = buf_res.frame_id;
	assign res.byte_index   = buf_res.byte_index;
	assign res.frame_length = buf_res.frame_length;

endmodule

`default_nettype wire

// File: rtl/sacfd_core.sv
// sacfd_core: frame parser state machine with running sum/add checks.
// Takes one byte per accepted request; depends on sacfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sacfd_core (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         take,
	input  wire logic [sacfd_pkg::BYTE_W-1:0] rx_byte,
	input  wire sacfd_pkg::cfg_regs_t         regs,
	output logic                              res_valid,
	output sacfd_pkg::result_t                res
);

	localparam logic [2:0] PH_HUNT = 3'd0;
	localparam logic [2:0] PH_ADDR = 3'd1;
	localparam logic [2:0] PH_ID   = 3'd2;
	localparam logic [2:0] PH_LEN  = 3'd3;
	localparam logic [2:0] PH_DATA = 3'd4;
	localparam logic [2:0] PH_SUM  = 3'd5;
	localparam logic [2:0] PH_ADD  = 3'd6;

	logic [2:0]                   phase_q, phase_d;
	logic [sacfd_pkg::BYTE_W-1:0] addr_q, addr_d;
	logic [sacfd_pkg::BYTE_W-1:0] ident_q, ident_d;
	logic [sacfd_pkg::BYTE_W-1:0] len_q, len_d;
	logic [sacfd_pkg::BYTE_W-1:0] count_q, count_d;
	logic [sacfd_pkg::BYTE_W-1:0] sum_q, sum_d;
	logic [sacfd_pkg::BYTE_W-1:0] add_q, add_d;
	logic                         match_q, match_d;
	logic [sacfd_pkg::BYTE_W-1:0] sum_next;
	logic [sacfd_pkg::BYTE_W-1:0] count_inc;
	logic                         ours;

	assign sum_next  = sum_q + rx_byte;
	assign count_inc = count_q + 8'd1;
	assign ours      = (addr_q == regs.accept_address);

	always_comb begin
		phase_d   = phase_q;
		addr_d    = addr_q;
		ident_d   = ident_q;
		len_d     = len_q;
		count_d   = count_q;
		sum_d     = sum_q;
		add_d     = add_q;
		match_d   = match_q;
		res_valid = 1'b0;
		res       = '{kind: sacfd_pkg::KIND_PAYLOAD, data_byte: rx_byte, frame_id: ident_q,
			byte_index: count_q, frame_length: len_q};
		case (phase_q)
			PH_ADDR: begin
				addr_d  = rx_byte;
				sum_d   = sum_next;
				add_d   = add_q + sum_next;
				phase_d = PH_ID;
			end
			PH_ID: begin
				ident_d = rx_byte;
				sum_d   = sum_next;
				add_d   = add_q + sum_next;
				phase_d = PH_LEN;
			end
			PH_LEN: begin
				len_d   = rx_byte;
				count_d = '0;
				sum_d   = sum_next;
				add_d   = add_q + sum_next;
				phase_d = (rx_byte == '0) ? PH_SUM : PH_DATA;
			end
			PH_DATA: begin
				sum_d     = sum_next;
				add_d     = add_q + sum_next;
				res_valid = ours;
				count_d   = count_inc;
				if (count_inc == len_q) begin
					phase_d = PH_SUM;
				end
			end
			PH_SUM: begin
				match_d = (rx_byte == sum_q);
				phase_d = PH_ADD;
			end
			PH_ADD: begin
				res_valid      = ours;
				res.kind       = (match_q && (rx_byte == add_q)) ?
					sacfd_pkg::KIND_GOOD : sacfd_pkg::KIND_BAD;
				res.data_byte  = '0;
				res.byte_index = '0;
				phase_d        = PH_HUNT;
			end
			default: begin
				// hunting; unused code falls here too
				phase_d = PH_HUNT;
				if (rx_byte == regs.header_value) begin
					sum_d   = rx_byte;
					add_d   = rx_byte;
					phase_d = PH_ADDR;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			addr_q  <= '0;
			ident_q <= '0;
			len_q   <= '0;
			count_q <= '0;
			sum_q   <= '0;
			add_q   <= '0;
			match_q <= 1'b0;
		end else if (take) begin
			phase_q <= phase_d;
			addr_q  <= addr_d;
			ident_q <= ident_d;
			len_q   <= len_d;
			count_q <= count_d;
			sum_q   <= sum_d;
			add_q   <= add_d;
			match_q <= match_d;
		end
	end

endmodule

`default_nettype wire

// File: rtl/sacfd_outbuf.sv
// sacfd_outbuf: two-entry result buffer between the parser and the consumer.
// Keeps the byte side moving while one result waits; depends on sacfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sacfd_outbuf (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               wr_en,
	input  wire sacfd_pkg::result_t wr_data,
	output logic                    not_full,
	output logic                    rd_valid,
	input  wire logic               rd_ready,
	output sacfd_pkg::result_t      rd_data
);

	sacfd_pkg::result_t entry_q [2];
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	logic [1:0]         count_q;
	logic               rd_en;

	assign not_full = (count_q != 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign rd_en    = rd_valid && rd_ready;
	assign rd_data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (rd_en) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: rtl/sacfd_checker.sv
// sacfd_checker: port-level assertions for the deframer, bound to the top level.
// Depends on sacfd_pkg and sum_add_check_frame_deframer.
`timescale 1ns / 1ps
`default_nettype none

module sacfd_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          rx_valid,
	input wire logic                          rx_ready,
	input wire logic                          res_valid,
	input wire logic                          res_ready,
	input wire logic [sacfd_pkg::KIND_W-1:0]  kind,
	input wire logic [sacfd_pkg::BYTE_W-1:0]  data_byte,
	input wire logic [sacfd_pkg::BYTE_W-1:0]  byte_index,
	input wire logic [sacfd_pkg::BYTE_W-1:0]  frame_length
);

	// a result held under stall keeps its fields
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(kind) && $stable(data_byte)
			&& $stable(byte_index))
		else $error("result changed while stalled");

	// results only appear after a byte request was taken
	a_res_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(rx_valid && rx_ready))
		else $error("result without a preceding byte request");

	a_kind_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (kind == sacfd_pkg::KIND_PAYLOAD || kind == sacfd_pkg::KIND_GOOD
			|| kind == sacfd_pkg::KIND_BAD))
		else $error("bad result kind");

	a_end_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && kind != sacfd_pkg::KIND_PAYLOAD |-> data_byte == '0 && byte_index == '0)
		else $error("frame end result carries payload data");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && kind == sacfd_pkg::KIND_PAYLOAD |-> byte_index < frame_length)
		else $error("payload index beyond frame length");

endmodule

bind sum_add_check_frame_deframer sacfd_checker u_sacfd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.rx_valid     (rx.valid),
	.rx_ready     (rx.ready),
	.res_valid    (res.valid),
	.res_ready    (res.ready),
	.kind         (res.kind),
	.data_byte    (res.data_byte),
	.byte_index   (res.byte_index),
	.frame_length (res.frame_length)
);

`default_nettype wire
